@@ hdl/lrr_pkg.sv @@
// Package for the range-limited Lehmer random source.
// Holds widths, generator constants, op codes and the command type; no dependencies.
`timescale 1ns / 1ps

package lrr_pkg;

  // field widths
  localparam int WORD_W = 32;
  localparam int SEED_W = 31;
  localparam int SPAN_W = 33;
  localparam int MULT_W = 15;
  localparam int PROD_W = SEED_W + MULT_W;
  localparam int STEP_W = $clog2(SEED_W);

  // generator constants
  localparam logic [MULT_W-1:0] LCG_MULT = MULT_W'(16807);
  localparam logic [SEED_W-1:0] LCG_MASK = SEED_W'(123459876);
  localparam logic [SEED_W:0]   LCG_MOD  = (SEED_W+1)'(32'h7FFF_FFFF);

  // default depth of the command queue
  localparam int CMD_DEPTH = 2;

  // input kind codes
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_SEED = 1'b1;

  // command op codes
  typedef logic [1:0] op_t;
  localparam op_t OP_SEED = 2'd0;
  localparam op_t OP_PASS = 2'd1;
  localparam op_t OP_DRAW = 2'd2;

  // classified command handed from front to back
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] lo;
    logic [SPAN_W-1:0] span;
    logic [SEED_W-1:0] seed;
  } cmd_t;

endpackage

@@ hdl/lrr_front.sv @@
// Front end: accepts input beats and classifies them into commands.
// Depends on lrr_pkg.
`timescale 1ns / 1ps

module lrr_front (
  input  logic                                in_push,
  input  logic                                in_kind,
  input  logic signed [lrr_pkg::WORD_W-1:0]   in_low_bound,
  input  logic signed [lrr_pkg::WORD_W-1:0]   in_high_bound,
  input  logic        [lrr_pkg::SEED_W-1:0]   in_new_seed,
  input  logic                                q_full,
  output logic                                q_wr,
  output lrr_pkg::cmd_t                       q_cmd
);

  logic signed [lrr_pkg::WORD_W-1:0] lo;
  logic signed [lrr_pkg::WORD_W-1:0] hi;
  logic signed [lrr_pkg::SPAN_W-1:0] diff;

  // take a beat whenever the queue has room
  assign q_wr = in_push && !q_full;

  // order the bounds and size the range exactly
  always_comb begin
    if (in_low_bound > in_high_bound) begin
      lo = in_high_bound;
      hi = in_low_bound;
    end else begin
      lo = in_low_bound;
      hi = in_high_bound;
    end
    diff = {hi[lrr_pkg::WORD_W-1], hi} - {lo[lrr_pkg::WORD_W-1], lo};
  end

  // build the command
  always_comb begin
    q_cmd.lo   = lo;
    q_cmd.span = lrr_pkg::SPAN_W'(diff) + lrr_pkg::SPAN_W'(1);
    q_cmd.seed = in_new_seed;
    if (in_kind == lrr_pkg::KIND_SEED) begin
      q_cmd.op = lrr_pkg::OP_SEED;
    end else if (in_low_bound == in_high_bound) begin
      q_cmd.op = lrr_pkg::OP_PASS;
    end else begin
      q_cmd.op = lrr_pkg::OP_DRAW;
    end
  end

endmodule

@@ hdl/lrr_cmd_fifo.sv @@
// Short command queue between the front end and the draw engine.
// Depends on lrr_pkg.
`timescale 1ns / 1ps

module lrr_cmd_fifo #(
  parameter int DEPTH = lrr_pkg::CMD_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  lrr_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd,
  output logic          empty,
  output lrr_pkg::cmd_t rd_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lrr_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_cmd = mem_r[rd_ptr_r];
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;

  // advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // hold entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

@@ hdl/lrr_back.sv @@
// Draw engine: seed step, Mersenne reduction, radix-2 remainder and result register.
// Depends on lrr_pkg.
`timescale 1ns / 1ps

module lrr_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmd_empty,
  input  lrr_pkg::cmd_t                       cmd,
  output logic                                cmd_pop,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [lrr_pkg::WORD_W-1:0]   out_value
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RED  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [lrr_pkg::SEED_W-1:0]   seed_r, seed_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [lrr_pkg::WORD_W-1:0]   out_value_r, out_value_nxt;
  logic [lrr_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic [lrr_pkg::WORD_W-1:0]   lo_r, lo_nxt;
  logic [lrr_pkg::SPAN_W-1:0]   span_r, span_nxt;
  logic [lrr_pkg::SEED_W-1:0]   dvd_r, dvd_nxt;
  logic [lrr_pkg::WORD_W-1:0]   rem_r, rem_nxt;
  logic [lrr_pkg::STEP_W-1:0]   step_r, step_nxt;

  logic                         out_free;
  logic [lrr_pkg::SEED_W-1:0]   x;
  logic [lrr_pkg::SEED_W:0]     fold;
  logic [lrr_pkg::SEED_W-1:0]   red;
  logic [lrr_pkg::SPAN_W-1:0]   rem_sh;

  assign out_empty = !out_valid_r;
  assign out_value = out_value_r;
  assign out_free  = !out_valid_r || out_pop;

  // scramble the seed and fold the product modulo 2^31-1
  assign x    = seed_r ^ lrr_pkg::LCG_MASK;
  assign fold = (lrr_pkg::SEED_W+1)'(prod_r[lrr_pkg::SEED_W-1:0])
              + (lrr_pkg::SEED_W+1)'(prod_r[lrr_pkg::PROD_W-1:lrr_pkg::SEED_W]);
  assign red  = (fold >= lrr_pkg::LCG_MOD) ? lrr_pkg::SEED_W'(fold - lrr_pkg::LCG_MOD)
                                           : lrr_pkg::SEED_W'(fold);

  // one restoring remainder step
  assign rem_sh = {rem_r, dvd_r[lrr_pkg::SEED_W-1]};

  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    prod_nxt      = prod_r;
    lo_nxt        = lo_r;
    span_nxt      = span_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    cmd_pop       = 1'b0;

    // drop the result once it is taken
    if (out_valid_r && out_pop) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            lrr_pkg::OP_SEED: begin
              cmd_pop  = 1'b1;
              seed_nxt = cmd.seed;
            end
            lrr_pkg::OP_PASS: begin
              if (out_free) begin
                cmd_pop       = 1'b1;
                out_valid_nxt = 1'b1;
                out_value_nxt = cmd.lo;
              end
            end
            lrr_pkg::OP_DRAW: begin
              cmd_pop   = 1'b1;
              lo_nxt    = cmd.lo;
              span_nxt  = cmd.span;
              prod_nxt  = lrr_pkg::PROD_W'(x) * lrr_pkg::PROD_W'(lrr_pkg::LCG_MULT);
              state_nxt = ST_RED;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_RED: begin
        seed_nxt  = red;
        dvd_nxt   = red;
        rem_nxt   = '0;
        step_nxt  = lrr_pkg::STEP_W'(lrr_pkg::SEED_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= span_r) begin
          rem_nxt = lrr_pkg::WORD_W'(rem_sh - span_r);
        end else begin
          rem_nxt = lrr_pkg::WORD_W'(rem_sh);
        end
        dvd_nxt = {dvd_r[lrr_pkg::SEED_W-2:0], 1'b0};
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r - lrr_pkg::STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = lo_r + rem_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold working payload
  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    prod_r      <= prod_nxt;
    lo_r        <= lo_nxt;
    span_r      <= span_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
  end

endmodule

@@ hdl/lehmer_random_in_range.sv @@
// Random integer source within a signed inclusive range, Lehmer generator.
// Top level; instantiates lrr_front, lrr_cmd_fifo and lrr_back, uses lrr_pkg.
//
// Usage:
//   Input channel (in_push / in_full): one beat is a draw (in_kind = 0) with
//   two signed bounds in either order, or a reseed (in_kind = 1) carrying
//   in_new_seed. Beats queue in a short command queue, so the sender keeps
//   pushing while the engine works.
//   Result channel (out_empty / out_pop): one signed out_value per draw, in
//   input order; a reseed gives no result.
//   A draw with distinct bounds passes through the engine as one multiply,
//   one modular fold, 31 radix-2 remainder steps and one writeback; the
//   iterative remainder unit takes no new draw until the last one is written
//   back. A draw with equal bounds or a reseed is handled in the idle state.
//   Reset clears the seed to zero and empties the queue and result register.
//   When the receiver stalls, the finished result holds in the output
//   register, the engine waits with its next result, and the input side
//   raises in_full once the command queue has filled.
`timescale 1ns / 1ps

module lehmer_random_in_range #(
  parameter int QUEUE_DEPTH = lrr_pkg::CMD_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic                                in_kind,
  input  logic signed [lrr_pkg::WORD_W-1:0]   in_low_bound,
  input  logic signed [lrr_pkg::WORD_W-1:0]   in_high_bound,
  input  logic        [lrr_pkg::SEED_W-1:0]   in_new_seed,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [lrr_pkg::WORD_W-1:0]   out_value
);

  logic          q_wr;
  lrr_pkg::cmd_t q_wr_cmd;
  logic          q_pop;
  logic          q_empty;
  lrr_pkg::cmd_t q_rd_cmd;

  // classify input beats
  lrr_front u_front (
    .in_push       (in_push),
    .in_kind       (in_kind),
    .in_low_bound  (in_low_bound),
    .in_high_bound (in_high_bound),
    .in_new_seed   (in_new_seed),
    .q_full        (in_full),
    .q_wr          (q_wr),
    .q_cmd         (q_wr_cmd)
  );

  // decouple front and engine
  lrr_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_cmd (q_wr_cmd),
    .full   (in_full),
    .rd     (q_pop),
    .empty  (q_empty),
    .rd_cmd (q_rd_cmd)
  );

  // run draws and hold results
  lrr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd       (q_rd_cmd),
    .cmd_pop   (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_value (out_value)
  );

endmodule

@@ hdl/lrr_checker.sv @@
// Port-level checker for lehmer_random_in_range, bound to the top level.
// Depends on lrr_pkg and the top level's ports.
`timescale 1ns / 1ps

module lrr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        in_kind,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_value
);

  logic [7:0] pending_r, pending_nxt;
  logic       draw_in, res_out;

  assign draw_in = in_push && !in_full && (in_kind == lrr_pkg::KIND_DRAW);
  assign res_out = out_pop && !out_empty;

  // count draws taken but not yet delivered
  always_comb begin
    pending_nxt = pending_r;
    if (draw_in && !res_out) begin
      pending_nxt = pending_r + 8'd1;
    end else if (res_out && !draw_in) begin
      pending_nxt = pending_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("queue full right after reset");

  a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> pending_r != 8'd0)
    else $error("result shown with no draw outstanding");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_value)))
    else $error("stalled result changed or vanished");

endmodule

bind lehmer_random_in_range lrr_checker u_lrr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .in_kind   (in_kind),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_value (out_value)
);

@@ test/tb_lehmer_random_in_range.sv @@
`timescale 1ns / 1ps
// Testbench for lehmer_random_in_range: directed range draws and reseeds, then random
// traffic, each result checked against an in-bench Schrage-form seed predictor.
// Depends on lrr_pkg and the lehmer_random_in_range RTL.

module tb_lehmer_random_in_range;

  localparam longint SCHRAGE_Q   = 127773;
  localparam longint SCHRAGE_R   = 2836;
  localparam longint LCG_MODULUS = 2147483647;
  localparam logic signed [lrr_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [lrr_pkg::WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic [lrr_pkg::SEED_W-1:0] SEED_ONES = '1;
  localparam int RANDOM_BEATS = 1650;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_LIMIT = 100;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_PERIODIC} pop_mode_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_push;
  logic                                in_full;
  logic                                in_kind;
  logic signed [lrr_pkg::WORD_W-1:0]   in_low_bound;
  logic signed [lrr_pkg::WORD_W-1:0]   in_high_bound;
  logic        [lrr_pkg::SEED_W-1:0]   in_new_seed;
  logic                                out_empty;
  logic                                out_pop;
  logic signed [lrr_pkg::WORD_W-1:0]   out_value;

  // predictor state and pending draw results, oldest first
  logic [lrr_pkg::SEED_W-1:0]          model_seed;
  logic signed [lrr_pkg::WORD_W-1:0]   pending_draws[$];
  logic signed [lrr_pkg::WORD_W-1:0]   oldest_draw;
  int                                  error_count;
  int                                  burst_left;
  int                                  cycle_count;
  pop_mode_t                           pop_mode = POP_ALWAYS;
  int                                  pop_mode_left = 0;
  int                                  pop_tick = 0;

  lehmer_random_in_range dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_kind       (in_kind),
    .in_low_bound  (in_low_bound),
    .in_high_bound (in_high_bound),
    .in_new_seed   (in_new_seed),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_value     (out_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one generator step: (16807 * (seed ^ mask)) mod (2^31 - 1), Schrage's form
  function automatic logic [lrr_pkg::SEED_W-1:0] lcg_next(
    input logic [lrr_pkg::SEED_W-1:0] s);
    longint x, q, r, t;
    x = longint'(s ^ lrr_pkg::LCG_MASK);
    q = x / SCHRAGE_Q;
    r = x % SCHRAGE_Q;
    t = longint'(lrr_pkg::LCG_MULT) * r - SCHRAGE_R * q;
    if (t < 0) t += LCG_MODULUS;
    return t[lrr_pkg::SEED_W-1:0];
  endfunction

  // update the seed copy and queue the value this beat must produce
  task automatic predict_beat(input logic kind,
                              input logic signed [lrr_pkg::WORD_W-1:0] lo,
                              input logic signed [lrr_pkg::WORD_W-1:0] hi,
                              input logic [lrr_pkg::SEED_W-1:0] sd);
    longint a, b, span, r;
    a = lo;
    b = hi;
    if (kind == lrr_pkg::KIND_SEED) begin
      model_seed = sd;
    end else if (a == b) begin
      pending_draws.push_back(lo);
    end else begin
      if (a > b) begin
        r = a;
        a = b;
        b = r;
      end
      model_seed = lcg_next(model_seed);
      span = b - a + 1;
      r = a + longint'(model_seed) % span;
      pending_draws.push_back(r[lrr_pkg::WORD_W-1:0]);
    end
  endtask

  // drive one beat, hold until accepted, then maybe idle for a gap
  task automatic send_beat(input logic kind,
                           input logic signed [lrr_pkg::WORD_W-1:0] lo,
                           input logic signed [lrr_pkg::WORD_W-1:0] hi,
                           input logic [lrr_pkg::SEED_W-1:0] sd);
    @(negedge clk);
    in_push       = 1'b1;
    in_kind       = kind;
    in_low_bound  = lo;
    in_high_bound = hi;
    in_new_seed   = sd;
    do @(posedge clk); while (in_full);
    predict_beat(kind, lo, hi, sd);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_push       = 1'b0;
      in_kind       = 1'($urandom_range(0, 1));
      in_low_bound  = $urandom;
      in_high_bound = $urandom;
      in_new_seed   = lrr_pkg::SEED_W'($urandom);
      repeat ($urandom_range(0, 11)) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  function automatic logic signed [lrr_pkg::WORD_W-1:0] corner_value();
    case ($urandom_range(0, 6))
      0:       return WORD_MIN;
      1:       return WORD_MIN + 1;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return WORD_MAX - 1;
      default: return WORD_MAX;
    endcase
  endfunction

  // first draws straight out of reset run from a zero seed
  task automatic test_reset_seed();
    send_beat(lrr_pkg::KIND_DRAW, 0, 9, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_DRAW, -5, 5, lrr_pkg::SEED_W'($urandom));
  endtask

  // equal bounds return the bound and hold the seed
  task automatic test_equal_bounds();
    send_beat(lrr_pkg::KIND_DRAW, 0, 0, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_DRAW, WORD_MIN, WORD_MIN, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_DRAW, WORD_MAX, WORD_MAX, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_DRAW, -1, -1, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_DRAW, 1000, 2000, lrr_pkg::SEED_W'($urandom));
  endtask

  task automatic test_reversed_bounds();
    send_beat(lrr_pkg::KIND_DRAW, 100, -100, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_DRAW, WORD_MAX, WORD_MIN, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_DRAW, 1, 0, lrr_pkg::SEED_W'($urandom));
  endtask

  // span of 2^32 and the two half-range spans
  task automatic test_full_range();
    send_beat(lrr_pkg::KIND_DRAW, WORD_MIN, WORD_MAX, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_DRAW, WORD_MIN, -1, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_DRAW, 0, WORD_MAX, lrr_pkg::SEED_W'($urandom));
  endtask

  // seed that XORs to all ones steps to zero; seed equal to the mask XORs to zero
  task automatic test_mask_corners();
    send_beat(lrr_pkg::KIND_SEED, $urandom, $urandom, ~lrr_pkg::LCG_MASK);
    send_beat(lrr_pkg::KIND_DRAW, WORD_MIN, WORD_MAX, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_DRAW, -7, 7, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_SEED, $urandom, $urandom, lrr_pkg::LCG_MASK);
    send_beat(lrr_pkg::KIND_DRAW, 0, 1000, lrr_pkg::SEED_W'($urandom));
  endtask

  // reseed ignores its bound fields and gives no result
  task automatic test_reseed_ignores_bounds();
    send_beat(lrr_pkg::KIND_SEED, -1, -1, SEED_ONES);
    send_beat(lrr_pkg::KIND_DRAW, -1, 1, lrr_pkg::SEED_W'($urandom));
    send_beat(lrr_pkg::KIND_SEED, WORD_MIN, WORD_MAX, '0);
    send_beat(lrr_pkg::KIND_DRAW, WORD_MAX - 1, WORD_MAX, lrr_pkg::SEED_W'($urandom));
  endtask

  // mostly draws over a mix of span shapes, with occasional reseeds
  task automatic test_random_traffic();
    logic                              kind;
    logic signed [lrr_pkg::WORD_W-1:0] lo, hi, tmp;
    logic [lrr_pkg::SEED_W-1:0]        sd;
    int                                i, k;
    for (i = 0; i < RANDOM_BEATS; i++) begin
      kind = ($urandom_range(0, 15) == 0) ? lrr_pkg::KIND_SEED : lrr_pkg::KIND_DRAW;
      lo   = $urandom;
      hi   = $urandom;
      sd   = lrr_pkg::SEED_W'($urandom);
      if (kind == lrr_pkg::KIND_SEED) begin
        case ($urandom_range(0, 7))
          0:       sd = lrr_pkg::LCG_MASK;
          1:       sd = ~lrr_pkg::LCG_MASK;
          2:       sd = '0;
          3:       sd = SEED_ONES;
          default: ;
        endcase
      end else begin
        case ($urandom_range(0, 9))
          4: hi = lo + $urandom_range(0, 16);
          5: hi = lo;
          6: begin
            k  = $urandom_range(1, 31);
            hi = lo + (32'd1 << k) - 32'd2 + $urandom_range(0, 2);
          end
          7: begin
            lo = corner_value();
            hi = corner_value();
          end
          8: begin
            lo = WORD_MIN;
            hi = WORD_MAX;
          end
          9: begin
            lo = $urandom_range(0, 2000) - 1000;
            hi = $urandom_range(0, 2000) - 1000;
          end
          default: ;
        endcase
        if ($urandom_range(0, 1) == 1) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      end
      send_beat(kind, lo, hi, sd);
    end
  endtask

  // receiver: switch between randomly chosen stall patterns
  always @(negedge clk) begin
    if (pop_mode_left == 0) begin
      pop_mode      = pop_mode_t'($urandom_range(0, 3));
      pop_mode_left = $urandom_range(16, 256);
    end else begin
      pop_mode_left--;
    end
    pop_tick++;
    case (pop_mode)
      POP_ALWAYS: out_pop = 1'b1;
      POP_COIN:   out_pop = 1'($urandom_range(0, 1));
      POP_SPARSE: out_pop = ($urandom_range(0, 9) == 0);
      default:    out_pop = ((pop_tick % 24) >= 18);
    endcase
  end

  // compare every popped beat with the oldest predicted draw
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_draws.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $error("out_value: expected no result, actual %0d", out_value);
      end else begin
        oldest_draw = pending_draws.pop_front();
        if (out_value !== oldest_draw) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $error("out_value: expected %0d, actual %0d", oldest_draw, out_value);
        end
      end
    end
  end

  // cap the run length
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_push       = 1'b0;
    in_kind       = lrr_pkg::KIND_DRAW;
    in_low_bound  = '0;
    in_high_bound = '0;
    in_new_seed   = '0;
    out_pop       = 1'b0;
    rst_n         = 1'b0;
    model_seed    = '0;
    error_count   = 0;
    burst_left    = $urandom_range(0, 40);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_seed();
    test_equal_bounds();
    test_reversed_bounds();
    test_full_range();
    test_mask_corners();
    test_reseed_ignores_bounds();
    test_random_traffic();

    // drain: wait for every draw, then watch for strays
    @(negedge clk);
    in_push = 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
